/* hw/rtl/cda_pkg.sv */
// Shared constants, field widths, reciprocal constants and calendar tables
// for the calendar date arithmetic block. No dependencies.
package cda_pkg;

    // Default upper year limit
    localparam int unsigned CDA_MAX_YEAR = 9999;

    // Field widths
    localparam int OP_W    = 2;
    localparam int YEAR_W  = 14;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;
    localparam int CNT_W   = 20;
    localparam int DIFF_W  = 22;

    // Internal widths: saturated year (covers limit up to 65535), day serial,
    // serial of the start of a year, decoded year, day of year
    localparam int KY_W    = 16;
    localparam int SER_W   = 26;
    localparam int BASE_W  = 25;
    localparam int FY_W    = 18;
    localparam int DOY_W   = 9;

    // Stage count before the output register, and the combine stage index
    localparam int PIPE_DEPTH = 12;
    localparam int C_STAGE    = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 2'd1;
    localparam logic [OP_W-1:0] OP_DIFF = 2'd2;

    localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

    // Cycle lengths in days
    localparam int DAYS_400Y = 146097;
    localparam int DAYS_100Y = 36524;
    localparam int DAYS_4Y   = 1461;
    localparam int DAYS_1Y   = 365;

    // Reciprocals, rounded up, for exact division of bounded values
    localparam logic [17:0] RCP_100   = 18'(((64'd1 << 24) + 64'd99) / 64'd100);
    localparam logic [27:0] RCP_400Y  = 28'(((64'd1 << 44) + 64'd146096) / 64'd146097);
    localparam logic [18:0] RCP_100Y  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [16:0] RCP_4Y    = 17'(((64'd1 << 27) + 64'd1460) / 64'd1461);
    localparam logic [11:0] RCP_1Y    = 12'(((64'd1 << 20) + 64'd364) / 64'd365);

    // Control and payload carried alongside the arithmetic
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [CNT_W-1:0]  cnt;
        logic              gt;
        logic              eq;
        logic              bad;
        logic [DIFF_W-1:0] diff;
    } ctl_t;

    // Length of a month (month already in 1..12)
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the year before the first of a month
    function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DOY_W-1:0] base;
        case (m)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + DOY_W'(leap && (m > 4'd2));
    endfunction

endpackage

/* hw/rtl/cda_to_serial.sv */
// Three-stage conversion of a date into a day serial (0 = year 1, Jan 1),
// saturating malformed fields first. Depends on cda_pkg.
module cda_to_serial
    import cda_pkg::*;
#(
    parameter int unsigned MAX_YEAR = CDA_MAX_YEAR
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [YEAR_W-1:0] year,
    input  logic [MON_W-1:0]  month,
    input  logic [DAY_W-1:0]  day,
    output logic [SER_W-1:0]  serial
);

    logic [KY_W-1:0]   k_reg, k_next;
    logic [33:0]       prod_reg, prod_next;
    logic [MON_W-1:0]  m1_reg, m1_next;
    logic [DAY_W-1:0]  d1_reg;

    logic [BASE_W-1:0] base_reg, base_next;
    logic              leap_reg, leap_next;
    logic [MON_W-1:0]  m2_reg;
    logic [DAY_W-1:0]  d2_reg;

    logic [SER_W-1:0]  serial_reg, serial_next;

    logic [KY_W-1:0]   y_ext;
    logic [KY_W-1:0]   ys;
    logic [9:0]        q;
    logic [KY_W-1:0]   r100;
    logic [DAY_W-1:0]  len;
    logic [DAY_W-1:0]  ds;

    // Saturate year and month, start the divide of year-1 by 100
    always_comb
    begin
        y_ext = KY_W'(year);
        if (y_ext == '0)
            ys = KY_W'(1);
        else if (y_ext > KY_W'(MAX_YEAR))
            ys = KY_W'(MAX_YEAR);
        else
            ys = y_ext;
        if (month == '0)
            m1_next = 4'd1;
        else if (month > 4'd12)
            m1_next = 4'd12;
        else
            m1_next = month;
        k_next    = ys - KY_W'(1);
        prod_next = 34'(k_next) * 34'(RCP_100);
    end

    // Leap flag and serial of January 1
    always_comb
    begin
        q         = prod_reg[33:24];
        r100      = k_reg - KY_W'(KY_W'(q) * KY_W'(100));
        leap_next = ((k_reg[1:0] == 2'b11) && (r100 != KY_W'(99)))
                    || ((r100 == KY_W'(99)) && (q[1:0] == 2'b11));
        base_next = BASE_W'(k_reg) * BASE_W'(365) + BASE_W'(k_reg >> 2)
                    - BASE_W'(q) + BASE_W'(q >> 2);
    end

    // Saturate the day and add the day of year
    always_comb
    begin
        len = month_len(m2_reg, leap_reg);
        if (d2_reg == '0)
            ds = 5'd1;
        else if (d2_reg > len)
            ds = len;
        else
            ds = d2_reg;
        serial_next = SER_W'(base_reg) + SER_W'(cum_days(m2_reg, leap_reg))
                      + SER_W'(ds) - SER_W'(1);
    end

    // Advance the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg      <= k_next;
            prod_reg   <= prod_next;
            m1_reg     <= m1_next;
            d1_reg     <= day;
            base_reg   <= base_next;
            leap_reg   <= leap_next;
            m2_reg     <= m1_reg;
            d2_reg     <= d1_reg;
            serial_reg <= serial_next;
        end
    end

    assign serial = serial_reg;

endmodule

/* hw/rtl/cda_from_serial.sv */
// Nine-stage conversion of a day serial back into year, month and day,
// dividing by the 400, 100, 4 and 1 year cycles. Depends on cda_pkg.
module cda_from_serial
    import cda_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [SER_W-1:0] serial,
    output logic [FY_W-1:0]  year,
    output logic [MON_W-1:0] month,
    output logic [DAY_W-1:0] day
);

    logic [SER_W-1:0] s1_reg, s2_reg;
    logic [53:0]      p1_reg, p1_next;
    logic [9:0]       n400_3_reg, n400_4_reg, n400_5_reg, n400_6_reg, n400_7_reg, n400_8_reg;
    logic [17:0]      r_reg, r4_reg, r_next;
    logic [36:0]      p2_reg, p2_next;
    logic [1:0]       n100_5_reg, n100_6_reg, n100_7_reg, n100_8_reg, n100_next;
    logic [15:0]      r2_reg, r2b_reg, r2_next;
    logic [32:0]      p3_reg, p3_next;
    logic [4:0]       n4_7_reg, n4_8_reg, n4_next;
    logic [10:0]      r3_reg, r3b_reg, r3_next;
    logic [22:0]      p4_reg, p4_next;
    logic [DOY_W-1:0] doy_reg, doy_next;
    logic [FY_W-1:0]  year_reg, year_next;
    logic             leap_reg, leap_next;

    logic [9:0]       n400;
    logic [2:0]       q100;
    logic [2:0]       q1;
    logic [1:0]       n1;
    logic [MON_W-1:0] mo;

    // Divide steps: a reciprocal multiply, then a remainder, for each cycle length
    always_comb
    begin
        p1_next   = 54'(s1_reg) * 54'(RCP_400Y);
        n400      = p1_reg[53:44];
        r_next    = 18'(s2_reg - SER_W'(n400) * SER_W'(DAYS_400Y));
        p2_next   = 37'(r_reg) * 37'(RCP_100Y);
        q100      = p2_reg[36:34];
        n100_next = (q100 > 3'd3) ? 2'd3 : q100[1:0];
        r2_next   = 16'(r4_reg - 18'(n100_next) * 18'(DAYS_100Y));
        p3_next   = 33'(r2_reg) * 33'(RCP_4Y);
        n4_next   = p3_reg[31:27];
        r3_next   = 11'(r2b_reg - 16'(n4_next) * 16'(DAYS_4Y));
        p4_next   = 23'(r3_reg) * 23'(RCP_1Y);
        q1        = p4_reg[22:20];
        n1        = (q1 > 3'd3) ? 2'd3 : q1[1:0];
        doy_next  = DOY_W'(r3b_reg - 11'(n1) * 11'(DAYS_1Y));
        year_next = FY_W'(n400_8_reg) * FY_W'(400) + FY_W'(n100_8_reg) * FY_W'(100)
                    + FY_W'(n4_8_reg) * FY_W'(4) + FY_W'(n1) + FY_W'(1);
        leap_next = (n1 == 2'd3) && ((n4_8_reg != 5'd24) || (n100_8_reg == 2'd3));
    end

    // Advance the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= serial;
            s2_reg     <= s1_reg;
            p1_reg     <= p1_next;
            n400_3_reg <= n400;
            r_reg      <= r_next;
            n400_4_reg <= n400_3_reg;
            p2_reg     <= p2_next;
            r4_reg     <= r_reg;
            n400_5_reg <= n400_4_reg;
            n100_5_reg <= n100_next;
            r2_reg     <= r2_next;
            n400_6_reg <= n400_5_reg;
            n100_6_reg <= n100_5_reg;
            p3_reg     <= p3_next;
            r2b_reg    <= r2_reg;
            n400_7_reg <= n400_6_reg;
            n100_7_reg <= n100_6_reg;
            n4_7_reg   <= n4_next;
            r3_reg     <= r3_next;
            n400_8_reg <= n400_7_reg;
            n100_8_reg <= n100_7_reg;
            n4_8_reg   <= n4_7_reg;
            p4_reg     <= p4_next;
            r3b_reg    <= r3_reg;
            doy_reg    <= doy_next;
            year_reg   <= year_next;
            leap_reg   <= leap_next;
        end
    end

    // Find the month by comparing against the month starts
    always_comb
    begin
        mo = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            if (doy_reg >= cum_days(MON_W'(i), leap_reg))
                mo = MON_W'(i);
        end
    end

    assign year  = year_reg;
    assign month = mo;
    assign day   = DAY_W'(doy_reg - cum_days(mo, leap_reg)) + DAY_W'(1);

endmodule

/* hw/rtl/calendar_date_arithmetic.sv */
// Calendar date arithmetic top level: input capture, operation stage,
// result selection and output register. Depends on cda_pkg,
// cda_to_serial and cda_from_serial.
//
// Usage:
//   Slave channel s_axis_* takes one request per handshake: the operation
//   in tuser, both dates and the day count in tdata. Master channel m_axis_*
//   returns one result per request in the same order: result date, day
//   difference and compare flags in tdata, the out-of-range flag in tuser.
//   The datapath is a 13-stage pipeline: two date-to-serial converters
//   (3 stages), a combinational add/subtract/difference step and a
//   serial-to-date converter (9 stages, dividing by constant-reciprocal
//   multiplies) plus the output register. A new request can enter every
//   cycle unless the output is stalled, so throughput is one item per
//   cycle. When the receiver holds m_axis_tready low with a result pending,
//   the whole pipeline freezes and s_axis_tready drops; nothing is lost or
//   repeated. Reset clears all valid bits; the block is ready right after.
module calendar_date_arithmetic
    import cda_pkg::*;
#(
    parameter int unsigned MAX_YEAR = CDA_MAX_YEAR
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year[13:0], month[17:14], day[22:18], day_count[42:23],
    // other_year[56:43], other_month[60:57], other_day[65:61], zero[71:66]
    input  logic [71:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_year[13:0], res_month[17:14], res_day[22:18],
    // day_difference[44:23], is_greater[45], is_equal[46], zero[47]
    output logic [47:0] m_axis_tdata,
    // out_of_range[0]
    output logic        m_axis_tuser
);

    logic              en;
    logic [PIPE_DEPTH-1:0] valid_reg;
    ctl_t              ctl_reg [PIPE_DEPTH];
    ctl_t              in_ctl, ctl_c, ctl_last;
    logic              out_valid_reg;
    logic [47:0]       out_data_reg, out_data_next;
    logic              out_oor_reg, out_oor_next;

    logic [YEAR_W-1:0] oyear;
    logic [MON_W-1:0]  omonth;
    logic [DAY_W-1:0]  oday;
    logic [SER_W-1:0]  sa, sb, s_c, dabs;
    logic [FY_W-1:0]   fy;
    logic [MON_W-1:0]  fm;
    logic [DAY_W-1:0]  fd;

    logic              arith;
    logic              bad;
    logic [YEAR_W-1:0] ry;
    logic [MON_W-1:0]  rm;
    logic [DAY_W-1:0]  rd;
    logic [DIFF_W-1:0] rdiff;

    // Advance everything unless a result is stuck at the output
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Unpack the request and compare the raw dates
    always_comb
    begin
        in_ctl.op    = s_axis_tuser;
        in_ctl.year  = s_axis_tdata[13:0];
        in_ctl.month = s_axis_tdata[17:14];
        in_ctl.day   = s_axis_tdata[22:18];
        in_ctl.cnt   = s_axis_tdata[42:23];
        oyear        = s_axis_tdata[56:43];
        omonth       = s_axis_tdata[60:57];
        oday         = s_axis_tdata[65:61];
        in_ctl.gt    = (in_ctl.year > oyear)
                       || ((in_ctl.year == oyear) && (in_ctl.month > omonth))
                       || ((in_ctl.year == oyear) && (in_ctl.month == omonth)
                           && (in_ctl.day > oday));
        in_ctl.eq    = (in_ctl.year == oyear) && (in_ctl.month == omonth)
                       && (in_ctl.day == oday);
        in_ctl.bad   = 1'b0;
        in_ctl.diff  = '0;
    end

    cda_to_serial #(.MAX_YEAR(MAX_YEAR)) u_ser_a
    (
        .clk    (clk),
        .en     (en),
        .year   (in_ctl.year),
        .month  (in_ctl.month),
        .day    (in_ctl.day),
        .serial (sa)
    );

    cda_to_serial #(.MAX_YEAR(MAX_YEAR)) u_ser_b
    (
        .clk    (clk),
        .en     (en),
        .year   (oyear),
        .month  (omonth),
        .day    (oday),
        .serial (sb)
    );

    // Add, subtract or take the distance of the serials
    always_comb
    begin
        ctl_c = ctl_reg[C_STAGE-1];
        s_c   = sa;
        dabs  = (sa > sb) ? (sa - sb) : (sb - sa);
        if ((ctl_c.op == OP_ADD) || (ctl_c.op == OP_SUB))
        begin
            ctl_c.diff = '0;
            if (ctl_c.op == OP_ADD)
            begin
                ctl_c.bad = 1'b0;
                s_c       = sa + SER_W'(ctl_c.cnt);
            end
            else
            begin
                ctl_c.bad = SER_W'(ctl_c.cnt) > sa;
                s_c       = sa - SER_W'(ctl_c.cnt);
            end
        end
        else
        begin
            ctl_c.bad  = 1'b0;
            ctl_c.diff = (dabs > SER_W'(DIFF_MAX)) ? DIFF_MAX : dabs[DIFF_W-1:0];
        end
    end

    cda_from_serial u_date
    (
        .clk    (clk),
        .en     (en),
        .serial (s_c),
        .year   (fy),
        .month  (fm),
        .day    (fd)
    );

    // Hold request fields alongside the datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0] <= in_ctl;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                ctl_reg[i] <= (i == C_STAGE) ? ctl_c : ctl_reg[i-1];
            end
        end
    end

    // Pick the result date and flags
    always_comb
    begin
        ctl_last = ctl_reg[PIPE_DEPTH-1];
        arith    = (ctl_last.op == OP_ADD) || (ctl_last.op == OP_SUB);
        bad      = ctl_last.bad || (fy > FY_W'(MAX_YEAR));
        ry       = ctl_last.year;
        rm       = ctl_last.month;
        rd       = ctl_last.day;
        rdiff    = ctl_last.diff;
        out_oor_next = 1'b0;
        if (arith)
        begin
            if (bad)
                out_oor_next = 1'b1;
            else
            begin
                ry = fy[YEAR_W-1:0];
                rm = fm;
                rd = fd;
            end
        end
        out_data_next = {1'b0, ctl_last.eq, ctl_last.gt, rdiff, rd, rm, ry};
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
            out_valid_reg <= valid_reg[PIPE_DEPTH-1];
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_oor_reg  <= out_oor_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_oor_reg;

endmodule

/* hw/rtl/cda_port_checker.sv */
// Port-level checks for calendar_date_arithmetic and the bind that
// attaches them. Depends on the top level's port list only.
module cda_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                               && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // An out-of-range result carries no day difference
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[44:23] == 22'd0))
        else $error("out-of-range result with nonzero difference");

    // The compare flags exclude each other
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[45] && m_axis_tdata[46]))
        else $error("greater and equal both set");

    // A stalled output blocks new requests, and a free output admits them
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("request ready does not follow the output state");

endmodule

bind calendar_date_arithmetic cda_port_checker u_port_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
